@@ rtl/fbca_pkg.sv @@
// Shared constants, codes and types for the FAT block chain allocator.
package fbca_pkg;

   localparam int DEF_BLOCK_COUNT     = 256;
   localparam int DEF_BYTES_PER_BLOCK = 64;

   localparam int BYTES_W  = 15;
   localparam int START_W  = 8;
   localparam int STATUS_W = 2;
   localparam int FIRST_W  = 8;
   localparam int FREE_W   = 9;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_SIZE  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_SPACE  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_START = 2'd3;

   typedef struct packed {
      logic               op;
      logic [START_W-1:0] chain_start;
   } cmd_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FIRST_W-1:0]  first_block;
      logic [FREE_W-1:0]   spare_blocks;
   } result_type;

   typedef struct packed {
      logic ready;
      logic res_valid;
   } eng_status_type;

endpackage

@@ rtl/fat_block_chain_allocator_top.sv @@
// Top level of the FAT block chain allocator with request and response handshakes.
//
// Channel  Direction  Handshake              Beat fields
// req      in         req_valid/req_ready    req_type, req_request_bytes, req_chain_start
// rsp      out        rsp_valid/rsp_ready    rsp_status, rsp_first_block, rsp_spare_blocks
//
// After reset every table entry is cleared to free while req_ready is low.
// An allocate scans the table from index 0, one table entry read per cycle, until it has
// taken enough free blocks; a rejected allocate goes straight to its response.
// A free walks the chain from its start block, each link read being dependent, and stops
// at the end mark, at an entry that is already free, or after BLOCK_COUNT blocks.
// A finished result moves to the response register before the next request is taken;
// while that register is still held, the block waits with req_ready low.
module fat_block_chain_allocator_top #(
   parameter int BLOCK_COUNT     = fbca_pkg::DEF_BLOCK_COUNT,
   parameter int BYTES_PER_BLOCK = fbca_pkg::DEF_BYTES_PER_BLOCK
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_type,
   input  logic [fbca_pkg::BYTES_W-1:0]  req_request_bytes,
   input  logic [fbca_pkg::START_W-1:0]  req_chain_start,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [fbca_pkg::STATUS_W-1:0] rsp_status,
   output logic [fbca_pkg::FIRST_W-1:0]  rsp_first_block,
   output logic [fbca_pkg::FREE_W-1:0]   rsp_spare_blocks
);
   import fbca_pkg::*;

   localparam int CNT_W = $clog2(BLOCK_COUNT + 1);

   logic             req_fire;
   logic             res_take;
   logic [CNT_W-1:0] need;
   logic             bad_size;
   cmd_type          cmd;
   eng_status_type   eng_status;
   result_type       res;
   result_type       rsp_ff;
   logic             rsp_valid_ff, rsp_valid_in;

   assign req_ready       = eng_status.ready;
   assign req_fire        = req_valid && req_ready;
   assign cmd.op          = req_type;
   assign cmd.chain_start = req_chain_start;
   assign res_take        = eng_status.res_valid && (!rsp_valid_ff || rsp_ready);

   fbca_size #(
      .BLOCK_COUNT     (BLOCK_COUNT),
      .BYTES_PER_BLOCK (BYTES_PER_BLOCK)
   ) u_size (
      .clock    (clock),
      .load     (req_fire),
      .bytes    (req_request_bytes),
      .need     (need),
      .bad_size (bad_size)
   );

   fbca_engine #(
      .BLOCK_COUNT (BLOCK_COUNT)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (req_fire),
      .cmd        (cmd),
      .need       (need),
      .bad_size   (bad_size),
      .res_take   (res_take),
      .eng_status (eng_status),
      .res        (res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_ff.status;
   assign rsp_first_block  = rsp_ff.first_block;
   assign rsp_spare_blocks = rsp_ff.spare_blocks;

endmodule

@@ rtl/fbca_size.sv @@
// Byte length to block count conversion and capacity check, registered per request.
module fbca_size #(
   parameter int BLOCK_COUNT     = fbca_pkg::DEF_BLOCK_COUNT,
   parameter int BYTES_PER_BLOCK = fbca_pkg::DEF_BYTES_PER_BLOCK,
   localparam int CNT_W          = $clog2(BLOCK_COUNT + 1)
) (
   input  logic                        clock,
   input  logic                        load,
   input  logic [fbca_pkg::BYTES_W-1:0] bytes,
   output logic [CNT_W-1:0]            need,
   output logic                        bad_size
);
   import fbca_pkg::*;

   localparam int CAPACITY    = BLOCK_COUNT * BYTES_PER_BLOCK;
   localparam int NUM_W       = BYTES_W + 1;
   localparam int RECIP_W     = NUM_W + 1;
   localparam int PROD_W      = NUM_W + RECIP_W;
   localparam int RECIP_SHIFT = NUM_W + $clog2(BYTES_PER_BLOCK);
   localparam longint unsigned RECIP_WIDE =
      ((64'd1 << RECIP_SHIFT) + 64'(BYTES_PER_BLOCK - 1)) / 64'(BYTES_PER_BLOCK);
   localparam logic [PROD_W-1:0] RECIP = PROD_W'(RECIP_WIDE);

   // The block count is a multiplication by the rounded-up reciprocal of the block
   // size, which is exact for every sum that fits in NUM_W bits.
   logic [NUM_W-1:0]  sum;
   logic [PROD_W-1:0] prod;
   logic [PROD_W-1:0] quot;
   logic [CNT_W-1:0]  need_ff;
   logic [CNT_W-1:0]  need_in;
   logic              bad_ff;
   logic              bad_in;

   always_comb begin
      sum  = NUM_W'(bytes) + NUM_W'(BYTES_PER_BLOCK - 1);
      prod = PROD_W'(sum) * RECIP;
      quot = prod >> RECIP_SHIFT;
      bad_in = 32'(bytes) > 32'(CAPACITY);
      if (quot == '0) begin
         need_in = CNT_W'(1);
      end else begin
         need_in = quot[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         need_ff <= need_in;
         bad_ff  <= bad_in;
      end
   end

   assign need     = need_ff;
   assign bad_size = bad_ff;

endmodule

@@ rtl/fbca_engine.sv @@
// Table memory and the sequencer that scans, links, walks and clears it one entry per cycle.
module fbca_engine #(
   parameter int BLOCK_COUNT = fbca_pkg::DEF_BLOCK_COUNT,
   localparam int CNT_W      = $clog2(BLOCK_COUNT + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     cmd_valid,
   input  fbca_pkg::cmd_type        cmd,
   input  logic [CNT_W-1:0]         need,
   input  logic                     bad_size,
   input  logic                     res_take,
   output fbca_pkg::eng_status_type eng_status,
   output fbca_pkg::result_type     res
);
   import fbca_pkg::*;

   localparam int IDX_W = $clog2(BLOCK_COUNT);
   localparam int ENT_W = $clog2(BLOCK_COUNT + 2);
   localparam logic [ENT_W-1:0] MARK_FREE = ENT_W'(BLOCK_COUNT);
   localparam logic [ENT_W-1:0] MARK_END  = ENT_W'(BLOCK_COUNT + 1);

   localparam logic [2:0] ST_CLEAR    = 3'd0;
   localparam logic [2:0] ST_IDLE     = 3'd1;
   localparam logic [2:0] ST_CHECK    = 3'd2;
   localparam logic [2:0] ST_SCAN     = 3'd3;
   localparam logic [2:0] ST_LINK_END = 3'd4;
   localparam logic [2:0] ST_WALK     = 3'd5;
   localparam logic [2:0] ST_DONE     = 3'd6;

   logic [ENT_W-1:0] mem [BLOCK_COUNT];

   logic [2:0]          state_ff, state_in;
   logic [IDX_W-1:0]    clr_ff, clr_in;
   logic [IDX_W-1:0]    scan_ff, scan_in;
   logic [IDX_W-1:0]    chk_addr_ff;
   logic                chk_vld_ff;
   logic [IDX_W-1:0]    prev_ff, prev_in;
   logic [CNT_W-1:0]    taken_ff, taken_in;
   logic [IDX_W-1:0]    first_ff, first_in;
   logic [IDX_W-1:0]    cur_ff, cur_in;
   logic [CNT_W-1:0]    steps_ff, steps_in;
   logic [CNT_W-1:0]    free_ff, free_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                op_ff, op_in;
   logic [START_W-1:0]  start_ff, start_in;
   logic [ENT_W-1:0]    rd_data_ff;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [ENT_W-1:0] wr_data;
   logic [IDX_W-1:0] rd_addr;
   logic [31:0]      start_wide;
   logic [IDX_W-1:0] start_idx;
   logic [31:0]      first_wide;
   logic [31:0]      free_wide;

   assign start_wide = 32'(start_ff);
   assign start_idx  = start_wide[IDX_W-1:0];

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      scan_in   = scan_ff;
      prev_in   = prev_ff;
      taken_in  = taken_ff;
      first_in  = first_ff;
      cur_in    = cur_ff;
      steps_in  = steps_ff;
      free_in   = free_ff;
      status_in = status_ff;
      op_in     = op_ff;
      start_in  = start_ff;
      wr_en     = 1'b0;
      wr_addr   = clr_ff;
      wr_data   = MARK_FREE;
      rd_addr   = scan_ff;
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + IDX_W'(1);
            if (clr_ff == IDX_W'(BLOCK_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd_valid) begin
               op_in    = cmd.op;
               start_in = cmd.chain_start;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            first_in  = '0;
            taken_in  = '0;
            scan_in   = '0;
            steps_in  = '0;
            cur_in    = start_idx;
            rd_addr   = start_idx;
            status_in = STATUS_OK;
            if (op_ff == OP_ALLOC) begin
               if (bad_size) begin
                  status_in = STATUS_BAD_SIZE;
                  state_in  = ST_DONE;
               end else if (free_ff < need) begin
                  status_in = STATUS_NO_SPACE;
                  state_in  = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end else begin
               if (start_wide >= 32'(BLOCK_COUNT)) begin
                  status_in = STATUS_BAD_START;
                  state_in  = ST_DONE;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_SCAN: begin
            rd_addr = scan_ff;
            scan_in = scan_ff + IDX_W'(1);
            if (chk_vld_ff && rd_data_ff == MARK_FREE) begin
               if (taken_ff == '0) begin
                  first_in = chk_addr_ff;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = prev_ff;
                  wr_data = ENT_W'(chk_addr_ff);
               end
               prev_in  = chk_addr_ff;
               taken_in = taken_ff + CNT_W'(1);
               if (taken_in == need) begin
                  state_in = ST_LINK_END;
               end
            end
         end
         ST_LINK_END: begin
            wr_en     = 1'b1;
            wr_addr   = prev_ff;
            wr_data   = MARK_END;
            free_in   = free_ff - need;
            status_in = STATUS_OK;
            state_in  = ST_DONE;
         end
         ST_WALK: begin
            rd_addr = rd_data_ff[IDX_W-1:0];
            if (rd_data_ff == MARK_FREE) begin
               status_in = (steps_ff == '0) ? STATUS_BAD_START : STATUS_OK;
               state_in  = ST_DONE;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = cur_ff;
               wr_data  = MARK_FREE;
               free_in  = free_ff + CNT_W'(1);
               steps_in = steps_ff + CNT_W'(1);
               cur_in   = rd_data_ff[IDX_W-1:0];
               if (rd_data_ff == MARK_END || steps_in == CNT_W'(BLOCK_COUNT)) begin
                  status_in = STATUS_OK;
                  state_in  = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         free_ff  <= CNT_W'(BLOCK_COUNT);
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         free_ff  <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff     <= scan_in;
      chk_addr_ff <= scan_ff;
      chk_vld_ff  <= (state_ff == ST_SCAN);
      prev_ff     <= prev_in;
      taken_ff    <= taken_in;
      first_ff    <= first_in;
      cur_ff      <= cur_in;
      steps_ff    <= steps_in;
      status_ff   <= status_in;
      op_ff       <= op_in;
      start_ff    <= start_in;
   end

   assign first_wide = 32'(first_ff);
   assign free_wide  = 32'(free_ff);

   assign eng_status.ready     = (state_ff == ST_IDLE);
   assign eng_status.res_valid = (state_ff == ST_DONE);
   assign res.status           = status_ff;
   assign res.first_block      = first_wide[FIRST_W-1:0];
   assign res.spare_blocks     = free_wide[FREE_W-1:0];

endmodule

@@ rtl/fbca_checker.sv @@
// Port-level checks on the allocator top level and the bind that attaches them.
module fbca_checker #(
   parameter int BLOCK_COUNT = fbca_pkg::DEF_BLOCK_COUNT
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [fbca_pkg::STATUS_W-1:0] rsp_status,
   input logic [fbca_pkg::FIRST_W-1:0]  rsp_first_block,
   input logic [fbca_pkg::FREE_W-1:0]   rsp_spare_blocks
);
   import fbca_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_first_block) && $stable(rsp_spare_blocks))
      else $error("Response beat changed while stalled.");

   a_first_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_first_block == '0)
      else $error("Failed request reported a non-zero first block.");

   a_free_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_spare_blocks) <= 32'(BLOCK_COUNT))
      else $error("Free block count exceeds the table size.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("Request side stayed ready after taking a beat.");

   a_clear_busy: assert property (@(posedge clock)
      $past(reset) && !reset |-> !req_ready)
      else $error("Request accepted before the table was cleared.");

endmodule

bind fat_block_chain_allocator_top fbca_checker #(
   .BLOCK_COUNT (BLOCK_COUNT)
) u_fbca_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_status       (rsp_status),
   .rsp_first_block  (rsp_first_block),
   .rsp_spare_blocks (rsp_spare_blocks)
);
